>>> rtl/quadratic_root_solver_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the solver RTL
// Checks are clocked on clk and are off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_ROOT_SOLVER_MACROS_SVH
`define QUADRATIC_ROOT_SOLVER_MACROS_SVH

// Check a property at every clock edge
`define QRS_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition leads to a consequence in the next cycle
`define QRS_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared widths, codes and job types of the quadratic root solver.
// ----------------------------------------------------------------------------
`default_nettype none

package qrs_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int COEF_W        = 32;
    localparam int TOL_W         = 16;
    localparam int D_W           = 66;           // discriminant magnitude
    localparam int ROOT_W        = D_W / 2;      // floor square root width
    localparam int NUM_W         = 35;           // signed numerator
    localparam int MAG_W         = NUM_W - 1;    // numerator magnitude
    localparam int DEN_W         = COEF_W + 1;   // magnitude of 2a or b
    localparam int QUO_W         = 32;
    localparam int QUEUE_DEPTH   = 4;

    localparam logic [QUO_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [QUO_W-1:0] SAT_NEG = 32'h8000_0000;

    typedef enum logic [1:0] {
        CLS_NONE = 2'd0,
        CLS_ONE  = 2'd1,
        CLS_TWO  = 2'd2,
        CLS_INF  = 2'd3
    } qrs_cls_t;

    // Data that rides alongside the square root
    typedef struct packed {
        qrs_cls_t                 cls;
        logic signed [NUM_W-1:0]  base;     // -b or -c
        logic                     den_neg;
        logic [DEN_W-1:0]         den_mag;  // |2a| or |b|
    } qrs_side_t;

    // One classified equation handed from front to back
    typedef struct packed {
        qrs_side_t        side;
        logic [D_W-1:0]   disc;            // zero unless two roots
    } qrs_job_t;

endpackage

`default_nettype wire

>>> rtl/qrs_front.sv
// ----------------------------------------------------------------------------
// qrs_front
// Accepts coefficients, squares and multiplies them, forms the discriminant
// and classifies the equation into a job for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_front
    import qrs_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [TOL_W-1:0]          tolerance,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic signed [COEF_W-1:0]  coef_square,
    input  wire logic signed [COEF_W-1:0]  coef_linear,
    input  wire logic signed [COEF_W-1:0]  coef_constant,
    output logic                           job_valid,
    input  wire logic                      job_ready,
    output qrs_job_t                       job
);

    function automatic logic [COEF_W-1:0] mag(input logic signed [COEF_W-1:0] v);
        mag = v[COEF_W-1] ? (~v + 1'b1) : v;
    endfunction

    logic                     advance;

    logic                     s1_valid_reg;
    logic signed [COEF_W-1:0] s1_a_reg, s1_b_reg, s1_c_reg;

    logic [COEF_W-1:0]        ma, mb, mc;
    logic                     s2_valid_reg;
    logic [2*COEF_W-1:0]      s2_bsq_reg, s2_prod_reg;
    logic                     s2_mixed_reg, s2_nza_reg, s2_nzb_reg, s2_nzc_reg;
    logic [COEF_W-1:0]        s2_ma_reg, s2_mb_reg;
    logic signed [COEF_W-1:0] s2_b_reg, s2_c_reg;
    logic                     s2_aneg_reg;

    logic [D_W-1:0]           four_p, bsq, disc_next;
    logic                     dneg_next;
    logic                     s3_valid_reg;
    logic [D_W-1:0]           s3_disc_reg;
    logic                     s3_dneg_reg, s3_nza_reg, s3_nzb_reg, s3_nzc_reg;
    logic [COEF_W-1:0]        s3_ma_reg, s3_mb_reg;
    logic signed [COEF_W-1:0] s3_b_reg, s3_c_reg;
    logic                     s3_aneg_reg;

    logic [D_W-1:0]           thr;
    logic                     above;
    logic signed [NUM_W-1:0]  b_ext, c_ext;

    // Whole front moves together; stall only when the last stage cannot push
    assign advance  = !s3_valid_reg || job_ready;
    assign in_ready = advance;

    // Stage 1: capture coefficients
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_a_reg <= coef_square;
            s1_b_reg <= coef_linear;
            s1_c_reg <= coef_constant;
        end
    end

    // Stage 2: magnitudes, near-zero tests, products
    assign ma = mag(s1_a_reg);
    assign mb = mag(s1_b_reg);
    assign mc = mag(s1_c_reg);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_bsq_reg   <= (2*COEF_W)'(mb) * (2*COEF_W)'(mb);
            s2_prod_reg  <= (2*COEF_W)'(ma) * (2*COEF_W)'(mc);
            s2_mixed_reg <= s1_a_reg[COEF_W-1] ^ s1_c_reg[COEF_W-1];
            s2_nza_reg   <= (ma == '0) || (ma < COEF_W'(tolerance));
            s2_nzb_reg   <= (mb == '0) || (mb < COEF_W'(tolerance));
            s2_nzc_reg   <= (mc == '0) || (mc < COEF_W'(tolerance));
            s2_ma_reg    <= ma;
            s2_mb_reg    <= mb;
            s2_b_reg     <= s1_b_reg;
            s2_c_reg     <= s1_c_reg;
            s2_aneg_reg  <= s1_a_reg[COEF_W-1];
        end
    end

    // Stage 3: discriminant magnitude and sign
    assign four_p = {s2_prod_reg, 2'b00};
    assign bsq    = D_W'(s2_bsq_reg);

    always_comb
    begin
        if (s2_prod_reg != '0 && s2_mixed_reg)
        begin
            disc_next = bsq + four_p;
            dneg_next = 1'b0;
        end
        else if (four_p <= bsq)
        begin
            disc_next = bsq - four_p;
            dneg_next = 1'b0;
        end
        else
        begin
            disc_next = four_p - bsq;
            dneg_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s3_disc_reg <= disc_next;
            s3_dneg_reg <= dneg_next;
            s3_nza_reg  <= s2_nza_reg;
            s3_nzb_reg  <= s2_nzb_reg;
            s3_nzc_reg  <= s2_nzc_reg;
            s3_ma_reg   <= s2_ma_reg;
            s3_mb_reg   <= s2_mb_reg;
            s3_b_reg    <= s2_b_reg;
            s3_c_reg    <= s2_c_reg;
            s3_aneg_reg <= s2_aneg_reg;
        end
    end

    // Classify and build the job
    assign thr   = D_W'(tolerance) << FRAC_BITS;
    assign above = s3_disc_reg > thr;
    assign b_ext = NUM_W'(s3_b_reg);
    assign c_ext = NUM_W'(s3_c_reg);

    always_comb
    begin
        job.disc         = '0;
        job.side.cls     = CLS_NONE;
        job.side.base    = -b_ext;
        job.side.den_neg = s3_aneg_reg;
        job.side.den_mag = {s3_ma_reg, 1'b0};
        if (s3_nza_reg)
        begin
            job.side.base    = -c_ext;
            job.side.den_neg = s3_b_reg[COEF_W-1];
            job.side.den_mag = DEN_W'(s3_mb_reg);
            if (!s3_nzb_reg)
                job.side.cls = CLS_ONE;
            else if (s3_nzc_reg)
                job.side.cls = CLS_INF;
            else
                job.side.cls = CLS_NONE;
        end
        else if (above && !s3_dneg_reg)
        begin
            job.side.cls = CLS_TWO;
            job.disc     = s3_disc_reg;
        end
        else if (above)
            job.side.cls = CLS_NONE;
        else
            job.side.cls = CLS_ONE;
    end

    assign job_valid = s3_valid_reg;

endmodule

`default_nettype wire

>>> rtl/qrs_queue.sv
// ----------------------------------------------------------------------------
// qrs_queue
// Short job queue between front and back so each side stalls on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_queue
    import qrs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     wr_valid,
    output logic          wr_ready,
    input  wire qrs_job_t wr_job,
    output logic          rd_valid,
    input  wire logic     rd_ready,
    output qrs_job_t      rd_job
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    qrs_job_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]       count_reg;
    logic                 push, pop;

    assign wr_ready = count_reg < (PTR_W+1)'(QUEUE_DEPTH);
    assign rd_valid = count_reg != '0;
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_job   = mem_reg[rd_ptr_reg];

    // Store a beat
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_job;
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

>>> rtl/qrs_sqrt.sv
// ----------------------------------------------------------------------------
// qrs_sqrt
// Pipelined floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_sqrt
    import qrs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [D_W-1:0]    disc,
    input  wire qrs_side_t         side_in,
    output logic                   out_valid,
    output logic [ROOT_W-1:0]      root,
    output qrs_side_t              side_out
);

    localparam int ITERS = ROOT_W;
    localparam int REM_W = ROOT_W + 3;

    logic                 v_reg    [ITERS+1];
    logic [ROOT_W-1:0]    root_reg [ITERS+1];
    qrs_side_t            side_reg [ITERS+1];
    logic [REM_W-1:0]     rem_reg  [ITERS];
    logic [D_W-1:0]       dsh_reg  [ITERS];

    logic [REM_W-1:0]     rem_next  [ITERS];
    logic [ROOT_W-1:0]    root_next [ITERS];
    logic [D_W-1:0]       dsh_next  [ITERS];

    // One trial subtraction per stage
    always_comb
    begin
        logic [REM_W-1:0] acc;
        logic [REM_W-1:0] trial;
        for (int k = 0; k < ITERS; k++)
        begin
            acc   = {rem_reg[k][REM_W-3:0], dsh_reg[k][D_W-1 -: 2]};
            trial = REM_W'({root_reg[k], 2'b01});
            if (acc >= trial)
            begin
                rem_next[k]  = acc - trial;
                root_next[k] = {root_reg[k][ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = acc;
                root_next[k] = {root_reg[k][ROOT_W-2:0], 1'b0};
            end
            dsh_next[k] = {dsh_reg[k][D_W-3:0], 2'b00};
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= ITERS; k++)
                v_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int k = 0; k < ITERS; k++)
                v_reg[k+1] <= v_reg[k];
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            dsh_reg[0]  <= disc;
            side_reg[0] <= side_in;
            for (int k = 0; k < ITERS; k++)
            begin
                root_reg[k+1] <= root_next[k];
                side_reg[k+1] <= side_reg[k];
            end
            for (int k = 0; k < ITERS-1; k++)
            begin
                rem_reg[k+1] <= rem_next[k];
                dsh_reg[k+1] <= dsh_next[k];
            end
        end
    end

    assign out_valid = v_reg[ITERS];
    assign root      = root_reg[ITERS];
    assign side_out  = side_reg[ITERS];

endmodule

`default_nettype wire

>>> rtl/qrs_div.sv
// ----------------------------------------------------------------------------
// qrs_div
// Pipelined restoring divider: (num << FRAC_BITS) / den, one quotient bit
// per stage, with a flag for quotients of 2^32 and above.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_div
    import qrs_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic              in_neg,
    input  wire logic [MAG_W-1:0]  num_mag,
    input  wire logic [DEN_W-1:0]  den_mag,
    input  wire qrs_cls_t          cls_in,
    output logic                   out_valid,
    output logic                   out_neg,
    output logic                   out_big,
    output logic [QUO_W-1:0]       quo,
    output qrs_cls_t               cls_out
);

    localparam int N_W  = MAG_W + FRAC_BITS;
    localparam int HI_W = N_W - QUO_W;

    logic [N_W-1:0]       n_full;
    logic [HI_W-1:0]      n_hi;

    logic                 v_reg   [QUO_W+1];
    logic                 neg_reg [QUO_W+1];
    logic                 big_reg [QUO_W+1];
    logic [QUO_W-1:0]     q_reg   [QUO_W+1];
    qrs_cls_t             cls_reg [QUO_W+1];
    logic [DEN_W-1:0]     rem_reg [QUO_W];
    logic [QUO_W-1:0]     low_reg [QUO_W];
    logic [DEN_W-1:0]     den_reg [QUO_W];

    logic [DEN_W-1:0]     rem_next [QUO_W];
    logic [QUO_W-1:0]     q_next   [QUO_W];
    logic [QUO_W-1:0]     low_next [QUO_W];

    assign n_full = {num_mag, {FRAC_BITS{1'b0}}};
    assign n_hi   = n_full[N_W-1:QUO_W];

    // One trial subtraction per stage
    always_comb
    begin
        logic [DEN_W:0] acc;
        logic [DEN_W:0] dext;
        for (int k = 0; k < QUO_W; k++)
        begin
            acc  = {rem_reg[k], low_reg[k][QUO_W-1]};
            dext = {1'b0, den_reg[k]};
            if (acc >= dext)
            begin
                rem_next[k] = DEN_W'(acc - dext);
                q_next[k]   = {q_reg[k][QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = DEN_W'(acc);
                q_next[k]   = {q_reg[k][QUO_W-2:0], 1'b0};
            end
            low_next[k] = {low_reg[k][QUO_W-2:0], 1'b0};
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= QUO_W; k++)
                v_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int k = 0; k < QUO_W; k++)
                v_reg[k+1] <= v_reg[k];
        end
    end

    // Advance payload; the first stage flags quotients that cannot fit
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= DEN_W'(n_hi);
            low_reg[0] <= n_full[QUO_W-1:0];
            den_reg[0] <= den_mag;
            q_reg[0]   <= '0;
            neg_reg[0] <= in_neg;
            big_reg[0] <= DEN_W'(n_hi) >= den_mag;
            cls_reg[0] <= cls_in;
            for (int k = 0; k < QUO_W; k++)
            begin
                q_reg[k+1]   <= q_next[k];
                neg_reg[k+1] <= neg_reg[k];
                big_reg[k+1] <= big_reg[k];
                cls_reg[k+1] <= cls_reg[k];
            end
            for (int k = 0; k < QUO_W-1; k++)
            begin
                rem_reg[k+1] <= rem_next[k];
                low_reg[k+1] <= low_next[k];
                den_reg[k+1] <= den_reg[k];
            end
        end
    end

    assign out_valid = v_reg[QUO_W];
    assign out_neg   = neg_reg[QUO_W];
    assign out_big   = big_reg[QUO_W];
    assign quo       = q_reg[QUO_W];
    assign cls_out   = cls_reg[QUO_W];

endmodule

`default_nettype wire

>>> rtl/qrs_back.sv
// ----------------------------------------------------------------------------
// qrs_back
// Carries out a job: square root, numerators, two divisions, saturation,
// and holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "quadratic_root_solver_macros.svh"

module qrs_back
    import qrs_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  job_valid,
    output logic                       job_ready,
    input  wire qrs_job_t              job,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output qrs_cls_t                   solution_class,
    output logic signed [QUO_W-1:0]    root_first,
    output logic signed [QUO_W-1:0]    root_second,
    output logic                       overflow
);

    // {overflow, value} of a saturated signed quotient
    function automatic logic [QUO_W:0] saturate(input logic neg, input logic big,
                                                input logic [QUO_W-1:0] q);
        if (neg)
        begin
            if (big || q > SAT_NEG)
                saturate = {1'b1, SAT_NEG};
            else
                saturate = {1'b0, QUO_W'(-q)};
        end
        else
        begin
            if (big || q[QUO_W-1])
                saturate = {1'b1, SAT_POS};
            else
                saturate = {1'b0, q};
        end
    endfunction

    logic                    en;
    logic                    sq_valid;
    logic [ROOT_W-1:0]       sq_root;
    qrs_side_t               sq_side;

    logic signed [NUM_W-1:0] s_ext, num1, num2;
    logic                    nv_reg;
    logic                    n1_neg_reg, n2_neg_reg;
    logic [MAG_W-1:0]        n1_mag_reg, n2_mag_reg;
    logic [DEN_W-1:0]        nd_mag_reg;
    qrs_cls_t                ncls_reg;

    logic                    d1_valid, d1_neg, d1_big, d2_neg, d2_big;
    logic [QUO_W-1:0]        d1_quo, d2_quo;
    qrs_cls_t                d1_cls;
    logic [QUO_W:0]          sat1, sat2;

    logic                    out_valid_reg;
    qrs_cls_t                cls_reg;
    logic [QUO_W-1:0]        r1_reg, r2_reg;
    logic                    ovf_reg;

    // Whole back stalls only while the output register is full and held
    assign en        = !out_valid_reg || out_ready;
    assign job_ready = en;

    qrs_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (job_valid),
        .disc      (job.disc),
        .side_in   (job.side),
        .out_valid (sq_valid),
        .root      (sq_root),
        .side_out  (sq_side)
    );

    // Form both numerators and their signs against the divisor
    assign s_ext = $signed({{(NUM_W-ROOT_W){1'b0}}, sq_root});
    assign num1  = sq_side.base + s_ext;
    assign num2  = sq_side.base - s_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            nv_reg <= 1'b0;
        else if (en)
            nv_reg <= sq_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n1_neg_reg <= num1[NUM_W-1] ^ sq_side.den_neg;
            n2_neg_reg <= num2[NUM_W-1] ^ sq_side.den_neg;
            n1_mag_reg <= num1[NUM_W-1] ? MAG_W'(-num1) : MAG_W'(num1);
            n2_mag_reg <= num2[NUM_W-1] ? MAG_W'(-num2) : MAG_W'(num2);
            nd_mag_reg <= sq_side.den_mag;
            ncls_reg   <= sq_side.cls;
        end
    end

    qrs_div #(.FRAC_BITS(FRAC_BITS)) u_div_first (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (nv_reg),
        .in_neg    (n1_neg_reg),
        .num_mag   (n1_mag_reg),
        .den_mag   (nd_mag_reg),
        .cls_in    (ncls_reg),
        .out_valid (d1_valid),
        .out_neg   (d1_neg),
        .out_big   (d1_big),
        .quo       (d1_quo),
        .cls_out   (d1_cls)
    );

    qrs_div #(.FRAC_BITS(FRAC_BITS)) u_div_second (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (nv_reg),
        .in_neg    (n2_neg_reg),
        .num_mag   (n2_mag_reg),
        .den_mag   (nd_mag_reg),
        .cls_in    (ncls_reg),
        .out_valid (),
        .out_neg   (d2_neg),
        .out_big   (d2_big),
        .quo       (d2_quo),
        .cls_out   ()
    );

    assign sat1 = saturate(d1_neg, d1_big, d1_quo);
    assign sat2 = saturate(d2_neg, d2_big, d2_quo);

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= d1_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cls_reg <= d1_cls;
            unique case (d1_cls)
                CLS_TWO:
                begin
                    r1_reg  <= sat1[QUO_W-1:0];
                    r2_reg  <= sat2[QUO_W-1:0];
                    ovf_reg <= sat1[QUO_W] | sat2[QUO_W];
                end
                CLS_ONE:
                begin
                    r1_reg  <= sat1[QUO_W-1:0];
                    r2_reg  <= '0;
                    ovf_reg <= sat1[QUO_W];
                end
                default:
                begin
                    r1_reg  <= '0;
                    r2_reg  <= '0;
                    ovf_reg <= 1'b0;
                end
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign solution_class = cls_reg;
    assign root_first     = r1_reg;
    assign root_second    = r2_reg;
    assign overflow       = ovf_reg;

    `QRS_CHECK(a_empty_roots_zero, (out_valid_reg && (cls_reg == CLS_NONE || cls_reg == CLS_INF)) |-> (r1_reg == '0 && r2_reg == '0 && !ovf_reg), "no-root result carries a root")
    `QRS_CHECK(a_single_root_second_zero, (out_valid_reg && cls_reg == CLS_ONE) |-> (r2_reg == '0), "single root result has a second root")
    `QRS_CHECK(a_overflow_saturated, (out_valid_reg && ovf_reg) |-> (r1_reg == SAT_POS || r1_reg == SAT_NEG || r2_reg == SAT_POS || r2_reg == SAT_NEG), "overflow without a saturated root")
    `QRS_CHECK_NEXT(a_stall_freezes_pipe, !en && nv_reg, nv_reg && $stable(n1_mag_reg), "pipeline moved during output stall")

endmodule

`default_nettype wire

>>> rtl/quadratic_root_solver.sv
// Throughput: one equation per cycle unless the output is held; the square root
// and both dividers are fully pipelined, one bit per stage, behind a 4-entry
// job queue.
// Reset: clears all pipeline valid bits and the job queue, and sets the
// tolerance register to 1.
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Real roots of a*x^2 + b*x + c = 0 in signed fixed point with saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module quadratic_root_solver
    import qrs_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [TOL_W-1:0]          cfg_wdata,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic signed [COEF_W-1:0]  coef_square,
    input  wire logic signed [COEF_W-1:0]  coef_linear,
    input  wire logic signed [COEF_W-1:0]  coef_constant,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [1:0]                     solution_class,
    output logic signed [QUO_W-1:0]        root_first,
    output logic signed [QUO_W-1:0]        root_second,
    output logic                           overflow
);

    logic [TOL_W-1:0] tolerance_reg;
    logic             fq_valid, fq_ready, qb_valid, qb_ready;
    qrs_job_t         fq_job, qb_job;
    qrs_cls_t         cls;

    // Hold the tolerance register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tolerance_reg <= TOL_W'(1);
        else if (cfg_we)
            tolerance_reg <= cfg_wdata;
    end

    qrs_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .tolerance     (tolerance_reg),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .coef_square   (coef_square),
        .coef_linear   (coef_linear),
        .coef_constant (coef_constant),
        .job_valid     (fq_valid),
        .job_ready     (fq_ready),
        .job           (fq_job)
    );

    qrs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_job   (fq_job),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_job   (qb_job)
    );

    qrs_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .job_valid      (qb_valid),
        .job_ready      (qb_ready),
        .job            (qb_job),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .solution_class (cls),
        .root_first     (root_first),
        .root_second    (root_second),
        .overflow       (overflow)
    );

    assign solution_class = cls;

endmodule

`default_nettype wire
